// ===== rtl/cbtc_pkg.sv =====
package cbtc_pkg;

  // Number formats: every value carries FRAC_BITS fraction bits.
  localparam int FRAC_BITS    = 16;
  localparam int BISECT_STEPS = 16;

  localparam int X_W       = 17;  // unsigned Q1.16: progress, x control points, s
  localparam int Y_W       = 19;  // signed Q3.16: y control points, eased
  localparam int CFG_IDX_W = 4;
  localparam int MUL_W     = 20;  // signed multiplier operand
  localparam int PROD_W    = 2 * MUL_W;
  localparam int TERM_W    = 22;  // floor(3*a*p / one) fits here
  localparam int SUM_W     = TERM_W + 1;
  localparam int STEP_W    = $clog2(BISECT_STEPS + 1);
  localparam int PHASE_W   = 3;

  localparam logic [X_W-1:0] ONE = X_W'(1) << FRAC_BITS;
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(7);

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_X1 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_Y1 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_X2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_Y2 = CFG_IDX_W'(3);

  // Register reset values.
  localparam logic [X_W-1:0] RST_X1 = X_W'(16384);
  localparam logic [Y_W-1:0] RST_Y1 = Y_W'(6554);
  localparam logic [X_W-1:0] RST_X2 = X_W'(16384);
  localparam logic [Y_W-1:0] RST_Y2 = Y_W'(65536);

  // Products of one curve evaluation, in issue order.
  typedef enum logic [PHASE_W-1:0] {
    OP_UU = 3'd0,  // (1-s)^2
    OP_SS = 3'd1,  // s^2
    OP_A  = 3'd2,  // (1-s)^2 s
    OP_B  = 3'd3,  // (1-s) s^2
    OP_C  = 3'd4,  // s^3
    OP_T1 = 3'd5,  // 3a * p1
    OP_T2 = 3'd6   // 3b * p2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE
  } state_t;

  typedef struct packed {
    logic start;       // load progress and reset the search interval
    logic issue;       // start a product on the multiplier
    op_t  op;          // which product
    logic final_eval;  // evaluate By at the lower bound
    logic decide;      // move one bound of the interval
    logic out_load;    // load the result register
  } cmd_t;

  typedef struct packed {
    logic out_blocked;  // result register holds an untaken result
  } sts_t;

endpackage

// ===== rtl/cbtc_ctrl.sv =====
module cbtc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cbtc_pkg::sts_t sts,
  output cbtc_pkg::cmd_t cmd
);

  cbtc_pkg::state_t state;
  cbtc_pkg::state_t state_next;
  logic [cbtc_pkg::PHASE_W-1:0] phase;
  logic [cbtc_pkg::STEP_W-1:0]  step;
  logic                         final_eval;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      cbtc_pkg::S_IDLE: begin
        if (in_valid) state_next = cbtc_pkg::S_EVAL;
      end
      cbtc_pkg::S_EVAL: begin
        if (phase == cbtc_pkg::PHASE_LAST) state_next = cbtc_pkg::S_DECIDE;
      end
      cbtc_pkg::S_DECIDE: begin
        if (!final_eval) begin
          state_next = cbtc_pkg::S_EVAL;
        end else if (!sts.out_blocked) begin
          state_next = cbtc_pkg::S_IDLE;
        end
      end
      default: state_next = cbtc_pkg::S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    in_ready       = (state == cbtc_pkg::S_IDLE);
    cmd.start      = (state == cbtc_pkg::S_IDLE) && in_valid;
    cmd.issue      = (state == cbtc_pkg::S_EVAL) && (phase != cbtc_pkg::PHASE_LAST);
    cmd.op         = cbtc_pkg::op_t'(phase);
    cmd.final_eval = final_eval;
    cmd.decide     = (state == cbtc_pkg::S_DECIDE) && !final_eval;
    cmd.out_load   = (state == cbtc_pkg::S_DECIDE) && final_eval && !sts.out_blocked;
  end

  // State, phase within one evaluation, and bisection step count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cbtc_pkg::S_IDLE;
      phase      <= '0;
      step       <= '0;
      final_eval <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cbtc_pkg::S_EVAL) begin
        phase <= phase + 1'b1;
      end else begin
        phase <= '0;
      end
      if (cmd.start) begin
        step       <= '0;
        final_eval <= 1'b0;
      end else if (cmd.decide) begin
        if (step == cbtc_pkg::STEP_W'(cbtc_pkg::BISECT_STEPS - 1)) begin
          final_eval <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/cbtc_dp.sv =====
module cbtc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  cbtc_pkg::cmd_t                  cmd,
  output cbtc_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [cbtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbtc_pkg::Y_W-1:0]        cfg_data,
  input  logic [cbtc_pkg::X_W-1:0]        progress,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [cbtc_pkg::Y_W-1:0] eased
);

  logic [cbtc_pkg::X_W-1:0] x1;
  logic [cbtc_pkg::X_W-1:0] x2;
  logic [cbtc_pkg::Y_W-1:0] y1;
  logic [cbtc_pkg::Y_W-1:0] y2;

  logic [cbtc_pkg::X_W-1:0] t;
  logic [cbtc_pkg::X_W-1:0] lo;
  logic [cbtc_pkg::X_W-1:0] hi;
  logic [cbtc_pkg::X_W:0]   lo_hi_sum;
  logic [cbtc_pkg::X_W-1:0] mid;
  logic [cbtc_pkg::X_W-1:0] s;
  logic [cbtc_pkg::X_W-1:0] u;

  logic [cbtc_pkg::X_W-1:0] uu;
  logic [cbtc_pkg::X_W-1:0] ss;
  logic [cbtc_pkg::X_W-1:0] a;
  logic [cbtc_pkg::X_W-1:0] b;
  logic [cbtc_pkg::X_W-1:0] c;
  logic [cbtc_pkg::X_W:0]   a3;
  logic [cbtc_pkg::X_W:0]   b3;
  logic signed [cbtc_pkg::TERM_W-1:0] t1;
  logic signed [cbtc_pkg::TERM_W-1:0] t2;

  logic signed [cbtc_pkg::Y_W-1:0]    p1;
  logic signed [cbtc_pkg::Y_W-1:0]    p2;
  logic signed [cbtc_pkg::MUL_W-1:0]  op_a;
  logic signed [cbtc_pkg::MUL_W-1:0]  op_b;
  logic signed [cbtc_pkg::PROD_W-1:0] prod;
  logic signed [cbtc_pkg::PROD_W-1:0] prod_sh;
  logic                               prod_vld;
  cbtc_pkg::op_t                      prod_op;

  logic signed [cbtc_pkg::SUM_W-1:0] bsum;
  logic                              below;
  logic                              fits;
  logic [cbtc_pkg::Y_W-1:0]          sat;

  // Configuration registers; x values keep their low 17 bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= cbtc_pkg::RST_X1;
      y1 <= cbtc_pkg::RST_Y1;
      x2 <= cbtc_pkg::RST_X2;
      y2 <= cbtc_pkg::RST_Y2;
    end else if (cfg_we) begin
      case (cfg_index)
        cbtc_pkg::REG_X1: x1 <= cfg_data[cbtc_pkg::X_W-1:0];
        cbtc_pkg::REG_Y1: y1 <= cfg_data;
        cbtc_pkg::REG_X2: x2 <= cfg_data[cbtc_pkg::X_W-1:0];
        cbtc_pkg::REG_Y2: y2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Curve parameter: the interval midpoint while searching, the lower bound at the end.
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = lo_hi_sum[cbtc_pkg::X_W:1];
  assign s         = cmd.final_eval ? lo : mid;
  assign u         = cbtc_pkg::ONE - s;
  assign a3        = {a, 1'b0} + {1'b0, a};
  assign b3        = {b, 1'b0} + {1'b0, b};

  // Control point weights: x zero-extended while searching, y for the final value.
  assign p1 = cmd.final_eval ? $signed(y1) : $signed({2'b00, x1});
  assign p2 = cmd.final_eval ? $signed(y2) : $signed({2'b00, x2});

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.op)
      cbtc_pkg::OP_UU: begin
        op_a = $signed({3'b000, u});
        op_b = $signed({3'b000, u});
      end
      cbtc_pkg::OP_SS: begin
        op_a = $signed({3'b000, s});
        op_b = $signed({3'b000, s});
      end
      cbtc_pkg::OP_A: begin
        op_a = $signed({3'b000, uu});
        op_b = $signed({3'b000, s});
      end
      cbtc_pkg::OP_B: begin
        op_a = $signed({3'b000, u});
        op_b = $signed({3'b000, ss});
      end
      cbtc_pkg::OP_C: begin
        op_a = $signed({3'b000, ss});
        op_b = $signed({3'b000, s});
      end
      cbtc_pkg::OP_T1: begin
        op_a = $signed({2'b00, a3});
        op_b = {p1[cbtc_pkg::Y_W-1], p1};
      end
      cbtc_pkg::OP_T2: begin
        op_a = $signed({2'b00, b3});
        op_b = {p2[cbtc_pkg::Y_W-1], p2};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Multiplier with a registered product; the op tag travels alongside.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.issue;
    end
    prod    <= op_a * op_b;
    prod_op <= cmd.op;
  end

  // Floor division by one is an arithmetic shift.
  assign prod_sh = prod >>> cbtc_pkg::FRAC_BITS;

  // Write back each product to its term register.
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      case (prod_op)
        cbtc_pkg::OP_UU: uu <= prod_sh[cbtc_pkg::X_W-1:0];
        cbtc_pkg::OP_SS: ss <= prod_sh[cbtc_pkg::X_W-1:0];
        cbtc_pkg::OP_A:  a  <= prod_sh[cbtc_pkg::X_W-1:0];
        cbtc_pkg::OP_B:  b  <= prod_sh[cbtc_pkg::X_W-1:0];
        cbtc_pkg::OP_C:  c  <= prod_sh[cbtc_pkg::X_W-1:0];
        cbtc_pkg::OP_T1: t1 <= prod_sh[cbtc_pkg::TERM_W-1:0];
        cbtc_pkg::OP_T2: t2 <= prod_sh[cbtc_pkg::TERM_W-1:0];
        default: ;
      endcase
    end
  end

  // Curve value and comparison with progress.
  assign bsum  = {t1[cbtc_pkg::TERM_W-1], t1} + {t2[cbtc_pkg::TERM_W-1], t2}
               + $signed({{(cbtc_pkg::SUM_W - cbtc_pkg::X_W){1'b0}}, c});
  assign below = bsum < $signed({{(cbtc_pkg::SUM_W - cbtc_pkg::X_W){1'b0}}, t});

  // Saturate to the signed Q3.16 range.
  assign fits = (bsum[cbtc_pkg::SUM_W-1:cbtc_pkg::Y_W-1] == '0)
             || (bsum[cbtc_pkg::SUM_W-1:cbtc_pkg::Y_W-1] == '1);
  always_comb begin
    if (fits) begin
      sat = bsum[cbtc_pkg::Y_W-1:0];
    end else if (bsum[cbtc_pkg::SUM_W-1]) begin
      sat = {1'b1, {(cbtc_pkg::Y_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(cbtc_pkg::Y_W - 1){1'b1}}};
    end
  end

  // Search interval.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      t  <= progress;
      lo <= '0;
      hi <= cbtc_pkg::ONE;
    end else if (cmd.decide) begin
      if (below) begin
        lo <= mid;
      end else begin
        hi <= mid;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) eased <= $signed(sat);
  end

  assign sts.out_blocked = out_valid && !out_ready;

endmodule

// ===== rtl/cubic_bezier_timing_curve.sv =====
// Cubic Bezier easing curve: takes progress t (unsigned Q1.16) and returns the eased value
// By(s) as signed Q3.16, saturated, where s is found by 16 halvings of [0,1] against Bx(s).
// Each curve evaluation runs seven products through one shared multiplier and ends with the
// bound update; an item makes 16 search evaluations plus one final evaluation, which loads
// the result register instead. The next input is taken only after that load, and the load
// waits while the output register still holds an untaken result. A finished result waits in
// an output register, and a new item is accepted meanwhile. The four control point registers
// are written through the configuration port; indexes beyond the list are ignored.
module cubic_bezier_timing_curve (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cbtc_pkg::X_W-1:0]        progress,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [cbtc_pkg::Y_W-1:0] eased,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cbtc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbtc_pkg::Y_W-1:0]        cfg_data
);

  cbtc_pkg::cmd_t cmd;
  cbtc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  cbtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cbtc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .progress  (progress),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .eased     (eased)
  );

  // The block is busy right after an input transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again directly after a transaction");

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("result register loaded while holding an untaken result");

  // Datapath commands are mutually exclusive.
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.issue, cmd.decide, cmd.out_load}))
    else $error("conflicting datapath commands");

  // The datapath issues no product and moves no bound while the block waits for input.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !cmd.issue && !cmd.decide)
    else $error("datapath active while idle");

endmodule
